// ----- hw/rtl/llsp_pkg.sv -----
// ----------------------------------------------------------------------------
// llsp_pkg
// Types and constants shared by the least-load server picker.
// ----------------------------------------------------------------------------
package llsp_pkg;

  localparam int OP_W     = 2;
  localparam int SRV_W    = 3;
  localparam int COST_W   = 16;
  localparam int LOAD_W   = 8;
  localparam int STATUS_W = 2;
  localparam int CFG_IW   = 1;
  localparam int CFG_DW   = 8;
  localparam int SIU_W    = 4;

  localparam logic [LOAD_W-1:0] MAX_LOAD_RST = 8'd8;
  localparam logic [SIU_W-1:0]  SIU_RST      = 4'd8;

  typedef enum logic [CFG_IW-1:0] {
    CFG_MAX_LOAD = 1'd0,
    CFG_SERVERS  = 1'd1
  } cfg_idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_DIST = 2'd0,
    OP_CPL  = 2'd1,
    OP_LINK = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 2'd0,
    STS_NONE     = 2'd1,
    STS_IDLE_ERR = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_CPL_READ,
    ST_FINISH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic in_ready;
    logic accept;
    logic scan;
    logic cpl_read;
    logic finish;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic            in_valid;
    logic [OP_W-1:0] in_op;
    logic            srv_ok;
    logic            clear_last;
    logic            scan_done;
    logic            out_free;
  } stat_t;

endpackage

// ----- hw/rtl/llsp_req_if.sv -----
// ----------------------------------------------------------------------------
// llsp_req_if
// Request channel: operation code and its operands.
// ----------------------------------------------------------------------------
interface llsp_req_if import llsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [SRV_W-1:0]  server;
  logic [SRV_W-1:0]  peer;
  logic [COST_W-1:0] link_cost;
  logic              link_present;

  modport source (output valid, op, server, peer, link_cost, link_present, input ready);
  modport sink (input valid, op, server, peer, link_cost, link_present, output ready);
endinterface

// ----- hw/rtl/llsp_rsp_if.sv -----
// ----------------------------------------------------------------------------
// llsp_rsp_if
// Response channel: chosen server, status and resulting load.
// ----------------------------------------------------------------------------
interface llsp_rsp_if import llsp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SRV_W-1:0]    chosen_server;
  logic [STATUS_W-1:0] status;
  logic [LOAD_W-1:0]   load_after;

  modport source (output valid, chosen_server, status, load_after, input ready);
  modport sink (input valid, chosen_server, status, load_after, output ready);
endinterface

// ----- hw/rtl/least_load_server_picker.sv -----
// ----------------------------------------------------------------------------
// least_load_server_picker
// Least-connections server picker with a per-pair link-cost table.
// ----------------------------------------------------------------------------
// Requests arrive on the req channel and each yields exactly one response on
// the rsp channel; a transfer takes place when valid and ready are both high.
// A link write stores one link-table entry, a distribute scans the peers of
// the start server and raises the chosen peer's count, and a complete lowers
// the count of a finished server.
// A distribute scans the peers of the start server one peer per cycle through
// the link and load memories, then passes the finish and done states, and
// skips the scan when the start server is outside the set in use. Complete
// reads the count in its own state before finish; link write and the spare op
// code go straight to finish. One request is in work at a time; ready rises
// again once the response is loaded into the output register, so the next
// request overlaps a waiting response. A stalled receiver holds the response
// and blocks the next one. After reset a clearing pass zeroes both memories;
// req.ready stays low meanwhile. Configuration writes are taken at any time
// but are meant for idle periods.
// ----------------------------------------------------------------------------
module least_load_server_picker import llsp_pkg::*; #(
  parameter int NUM_SERVERS = 8,
  parameter int COST_BITS   = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  llsp_req_if.sink          req,
  llsp_rsp_if.source        rsp
);

  cmd_t  cmd;
  stat_t stat;

  llsp_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  llsp_dpath #(
    .NUM_SERVERS (NUM_SERVERS),
    .COST_BITS   (COST_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .req       (req),
    .rsp       (rsp)
  );

endmodule

// ----- hw/rtl/llsp_ram.sv -----
// ----------------------------------------------------------------------------
// llsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module llsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/llsp_ctrl.sv -----
// ----------------------------------------------------------------------------
// llsp_ctrl
// Sequencer for clearing, peer scan, completion and result hand-off.
// ----------------------------------------------------------------------------
module llsp_ctrl import llsp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (stat.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (stat.in_valid) begin
          if (stat.in_op == OP_DIST) begin
            state_next = stat.srv_ok ? ST_SCAN : ST_FINISH;
          end else if (stat.in_op == OP_CPL) begin
            state_next = ST_CPL_READ;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (stat.scan_done) state_next = ST_FINISH;
      end
      ST_CPL_READ: state_next = ST_FINISH;
      ST_FINISH:   state_next = ST_DONE;
      ST_DONE: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_CLEAR:    cmd.clear = 1'b1;
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.accept   = stat.in_valid;
      end
      ST_SCAN:     cmd.scan = 1'b1;
      ST_CPL_READ: cmd.cpl_read = 1'b1;
      ST_FINISH:   cmd.finish = 1'b1;
      ST_DONE:     cmd.out_load = stat.out_free;
      default:     cmd = '0;
    endcase
  end

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.in_ready |-> state == ST_IDLE)
    else $error("request ready outside idle");

  a_finish_then_done: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> state == ST_DONE)
    else $error("finish not followed by result hand-off");

  a_scan_entry: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && stat.in_op == OP_DIST && stat.srv_ok |=> cmd.scan)
    else $error("distribute did not start a scan");

endmodule

// ----- hw/rtl/llsp_dpath.sv -----
// ----------------------------------------------------------------------------
// llsp_dpath
// Load counters, link table, peer scan and response register.
// ----------------------------------------------------------------------------
module llsp_dpath import llsp_pkg::*; #(
  parameter int NUM_SERVERS = 8,
  parameter int COST_BITS   = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  input  cmd_t              cmd,
  output stat_t             stat,
  llsp_req_if.sink          req,
  llsp_rsp_if.source        rsp
);

  localparam int SW = $clog2(NUM_SERVERS);
  localparam int CW = $clog2(NUM_SERVERS + 1);
  localparam int XW = (CW > 4) ? CW : 4;
  localparam int LD = NUM_SERVERS * NUM_SERVERS;
  localparam int LW = $clog2(LD);
  localparam int EW = COST_BITS + 1;

  logic [LOAD_W-1:0] max_load;
  logic [SIU_W-1:0]  siu;

  logic [LW-1:0]       clr;
  logic [OP_W-1:0]     op_reg;
  logic [SRV_W-1:0]    srv_reg;
  logic [LW-1:0]       base;
  logic [XW-1:0]       idx;
  logic                pv;
  logic [SW-1:0]       pidx;
  logic                taken;
  logic [SW-1:0]       pick;
  logic [LOAD_W-1:0]   best_load;
  logic [COST_BITS-1:0] last_cost;

  logic [SRV_W-1:0]  res_srv;
  status_t           res_status;
  logic [LOAD_W-1:0] res_load;
  logic              out_valid;
  logic [SRV_W-1:0]  out_srv;
  status_t           out_status;
  logic [LOAD_W-1:0] out_load;

  logic [XW-1:0] used_x;
  logic [XW-1:0] srv_x;
  logic [XW-1:0] srv_in_x;
  logic [XW-1:0] peer_in_x;
  logic          issue;
  logic          qual;
  logic          take;
  logic          cpl_ok;

  logic              link_we;
  logic [LW-1:0]     link_waddr;
  logic [EW-1:0]     link_wdata;
  logic [LW-1:0]     link_raddr;
  logic [EW-1:0]     link_rd;
  logic              load_we;
  logic [SW-1:0]     load_waddr;
  logic [LOAD_W-1:0] load_wdata;
  logic [SW-1:0]     load_raddr;
  logic [LOAD_W-1:0] load_rd;

  assign used_x    = (XW'(siu) < XW'(NUM_SERVERS)) ? XW'(siu) : XW'(NUM_SERVERS);
  assign srv_x     = XW'(srv_reg);
  assign srv_in_x  = XW'(req.server);
  assign peer_in_x = XW'(req.peer);
  assign issue     = cmd.scan && (idx < used_x);
  assign qual      = pv && (XW'(pidx) != srv_x) && link_rd[COST_BITS]
                     && (load_rd < max_load);
  assign take      = qual && (!taken || (load_rd < best_load)
                     || (link_rd[COST_BITS-1:0] < last_cost));
  assign cpl_ok    = (srv_x < used_x) && (load_rd != '0);

  assign stat.in_valid   = req.valid;
  assign stat.in_op      = req.op;
  assign stat.srv_ok     = srv_in_x < used_x;
  assign stat.clear_last = clr == LW'(LD - 1);
  assign stat.scan_done  = !issue && !pv;
  assign stat.out_free   = !out_valid || rsp.ready;

  assign req.ready         = cmd.in_ready;
  assign rsp.valid         = out_valid;
  assign rsp.chosen_server = out_srv;
  assign rsp.status        = out_status;
  assign rsp.load_after    = out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_load <= MAX_LOAD_RST;
      siu      <= SIU_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_LOAD: max_load <= cfg_data;
        CFG_SERVERS:  siu      <= cfg_data[SIU_W-1:0];
        default:      max_load <= max_load;
      endcase
    end
  end

  always_comb begin
    link_we    = 1'b0;
    link_waddr = LW'(srv_in_x[SW-1:0]) * LW'(NUM_SERVERS) + LW'(peer_in_x[SW-1:0]);
    link_wdata = {req.link_present, COST_BITS'(req.link_cost)};
    if (cmd.clear) begin
      link_we    = 1'b1;
      link_waddr = clr;
      link_wdata = '0;
    end else if (cmd.accept && req.op == OP_LINK && srv_in_x < XW'(NUM_SERVERS)
                 && peer_in_x < XW'(NUM_SERVERS)) begin
      link_we = 1'b1;
    end
  end

  assign link_raddr = base + LW'(idx[SW-1:0]);
  assign load_raddr = cmd.cpl_read ? srv_x[SW-1:0] : idx[SW-1:0];

  always_comb begin
    load_we    = 1'b0;
    load_waddr = srv_x[SW-1:0];
    load_wdata = 8'(load_rd - 8'd1);
    if (cmd.clear) begin
      load_we    = clr < LW'(NUM_SERVERS);
      load_waddr = clr[SW-1:0];
      load_wdata = '0;
    end else if (cmd.finish && op_reg == OP_DIST && taken) begin
      load_we    = 1'b1;
      load_waddr = pick;
      load_wdata = 8'(best_load + 8'd1);
    end else if (cmd.finish && op_reg == OP_CPL && cpl_ok) begin
      load_we = 1'b1;
    end
  end

  llsp_ram #(.WIDTH(EW), .DEPTH(LD)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rd)
  );

  llsp_ram #(.WIDTH(LOAD_W), .DEPTH(NUM_SERVERS)) u_load_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (load_waddr),
    .wdata (load_wdata),
    .raddr (load_raddr),
    .rdata (load_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (cmd.clear) begin
      clr <= LW'(clr + LW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      pv    <= 1'b0;
      taken <= 1'b0;
    end else if (cmd.accept) begin
      idx   <= '0;
      pv    <= 1'b0;
      taken <= 1'b0;
    end else if (cmd.scan) begin
      pv <= issue;
      if (issue) idx <= XW'(idx + XW'(1));
      if (take) taken <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_reg  <= req.op;
      srv_reg <= req.server;
      base    <= LW'(srv_in_x[SW-1:0]) * LW'(NUM_SERVERS);
    end
    if (cmd.scan) begin
      pidx <= idx[SW-1:0];
      if (take) begin
        pick      <= pidx;
        best_load <= load_rd;
        last_cost <= link_rd[COST_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_srv    <= srv_reg;
      res_status <= STS_OK;
      res_load   <= '0;
      case (op_reg)
        OP_DIST: begin
          if (taken) begin
            res_srv  <= SRV_W'(pick);
            res_load <= 8'(best_load + 8'd1);
          end else begin
            res_status <= STS_NONE;
          end
        end
        OP_CPL: begin
          if (cpl_ok) begin
            res_load <= 8'(load_rd - 8'd1);
          end else begin
            res_status <= STS_IDLE_ERR;
          end
        end
        default: res_status <= STS_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_srv    <= res_srv;
      out_status <= res_status;
      out_load   <= res_load;
    end
  end

  a_pick_not_start: assert property (@(posedge clk) disable iff (rst)
    taken |-> XW'(pick) != srv_x)
    else $error("start server picked as its own peer");

  a_peer_in_range: assert property (@(posedge clk) disable iff (rst)
    pv |-> XW'(pidx) < used_x)
    else $error("scan read a peer outside the servers in use");

  a_pick_below_limit: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && op_reg == OP_DIST && taken |-> best_load < max_load)
    else $error("picked server already at the load limit");

endmodule
